// File: rtl/bmm_pkg.sv
// ----------------------------------------------------------------------------
// bmm_pkg
// shared constants and state encoding for the bipartite matching block
// ----------------------------------------------------------------------------
package bmm_pkg;

  localparam int unsigned MaxUsersDef  = 32;
  localparam int unsigned MaxCitiesDef = 64;

  localparam int unsigned HomeW = 6;
  localparam int unsigned MaskW = 64;
  localparam int unsigned IdxW  = 5;
  localparam int unsigned TotW  = 6;

  typedef enum logic [4:0] {
    S_LOAD,
    S_INIT,
    S_BU,
    S_BUW,
    S_BV,
    S_BVW,
    S_LI,
    S_LIW,
    S_LQ,
    S_LQW,
    S_LQA,
    S_LV,
    S_LVW,
    S_LVD,
    S_AU,
    S_AUW,
    S_AF,
    S_AFW,
    S_AN,
    S_ANW,
    S_AND,
    S_APW,
    S_AC,
    S_ACW,
    S_OR,
    S_OW
  } bmm_state_e;

endpackage

// File: rtl/bmm_ram.sv
// ----------------------------------------------------------------------------
// bmm_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module bmm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/bipartite_max_matching_top.sv
// ----------------------------------------------------------------------------
// bipartite_max_matching_top
// loads user records, builds the want-graph and runs hopcroft-karp matching
// ----------------------------------------------------------------------------
// load: one beat per cycle, no result until the beat flagged last_user
// after last beat: partner and layer rams cleared for all MaxUsers entries, adjacency built
// per phase: layering walk, then augmenting searches over the row bits of the n stored
//   users; a set bit looks up the partner and its layer
// results: one beat per stored user, each once the last is taken; loading resumes once
//   the last beat sits in the output register; reset: async active low, control only
// ----------------------------------------------------------------------------
module bipartite_max_matching_top
  import bmm_pkg::*;
#(
  parameter int unsigned MaxUsers  = MaxUsersDef,
  parameter int unsigned MaxCities = MaxCitiesDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [HomeW-1:0] home_city_i,
  input  logic [MaskW-1:0] desired_mask_i,
  input  logic             last_user_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [IdxW-1:0]  user_index_o,
  output logic             is_matched_o,
  output logic [IdxW-1:0]  partner_index_o,
  output logic             has_guest_o,
  output logic [IdxW-1:0]  guest_index_o,
  output logic [TotW-1:0]  matched_total_o,
  output logic             overflow_o,
  output logic             last_result_o
);

  localparam int unsigned Iw  = $clog2(MaxUsers);      // user index
  localparam int unsigned Cw  = $clog2(MaxUsers + 1);  // counts up to MaxUsers
  localparam int unsigned Pw  = Iw + 1;                // {valid, index}
  localparam int unsigned Dw  = Cw + 1;                // {valid, layer}
  localparam int unsigned Sw  = Iw + Cw;               // {node, next}
  localparam int unsigned Rw  = HomeW + MaskW;         // {home, mask}

  localparam logic [Cw-1:0] CntMax = Cw'(MaxUsers);
  localparam logic [Cw-1:0] One    = Cw'(1);

  bmm_state_e state_q, state_d;

  logic [Cw-1:0]       cnt_q, cnt_d;
  logic                ovf_q, ovf_d;
  logic [Cw-1:0]       u_q, u_d;        // outer loop, root of a search
  logic [Cw-1:0]       v_q, v_d;        // inner loop, next neighbor
  logic [MaxUsers-1:0] row_q, row_d;
  logic [MaskW-1:0]    mask_q, mask_d;
  logic [Cw-1:0]       head_q, head_d;
  logic [Cw-1:0]       tail_q, tail_d;
  logic                found_q, found_d;
  logic [Cw-1:0]       du_q, du_d;
  logic [Iw-1:0]       node_q, node_d;
  logic [Iw-1:0]       w_q, w_d;
  logic [Cw-1:0]       sp_q, sp_d;
  logic [Cw-1:0]       k_q, k_d;
  logic [Cw-1:0]       match_q, match_d;

  // result register
  logic                out_valid_q, out_valid_d;
  logic                out_load;
  logic [Iw-1:0]       res_user_q;
  logic [Pw-1:0]       res_lp_q, res_rp_q;
  logic [Cw-1:0]       res_tot_q;
  logic                res_ovf_q, res_last_q;

  // ram ports
  logic          rec_we;
  logic [Iw-1:0] rec_waddr, rec_raddr;
  logic [Rw-1:0] rec_wdata, rec_rdata;

  logic                adj_we;
  logic [Iw-1:0]       adj_waddr, adj_raddr;
  logic [MaxUsers-1:0] adj_wdata, adj_rdata;

  logic          lp_we, rp_we, dist_we, q_we, st_we;
  logic [Iw-1:0] lp_waddr, lp_raddr, rp_waddr, rp_raddr;
  logic [Iw-1:0] dist_waddr, dist_raddr, q_waddr, q_raddr, st_waddr, st_raddr;
  logic [Pw-1:0] lp_wdata, lp_rdata, rp_wdata, rp_rdata;
  logic [Dw-1:0] dist_wdata, dist_rdata;
  logic [Iw-1:0] q_wdata, q_rdata;
  logic [Sw-1:0] st_wdata, st_rdata;

  logic [HomeW-1:0] bv_home;
  logic             bv_bit;

  assign bv_home = rec_rdata[MaskW +: HomeW];
  assign bv_bit  = (v_q != u_q) && ({1'b0, bv_home} < 7'(MaxCities)) && mask_q[bv_home];

  assign in_ready_o = (state_q == S_LOAD);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    ovf_d     = ovf_q;
    u_d       = u_q;
    v_d       = v_q;
    row_d     = row_q;
    mask_d    = mask_q;
    head_d    = head_q;
    tail_d    = tail_q;
    found_d   = found_q;
    du_d      = du_q;
    node_d    = node_q;
    w_d       = w_q;
    sp_d      = sp_q;
    k_d       = k_q;
    match_d   = match_q;
    out_load  = 1'b0;

    rec_we     = 1'b0;
    rec_waddr  = cnt_q[Iw-1:0];
    rec_wdata  = {home_city_i, desired_mask_i};
    rec_raddr  = u_q[Iw-1:0];
    adj_we     = 1'b0;
    adj_waddr  = u_q[Iw-1:0];
    adj_wdata  = row_q;
    adj_raddr  = node_q;
    lp_we      = 1'b0;
    lp_waddr   = u_q[Iw-1:0];
    lp_wdata   = '0;
    lp_raddr   = u_q[Iw-1:0];
    rp_we      = 1'b0;
    rp_waddr   = u_q[Iw-1:0];
    rp_wdata   = '0;
    rp_raddr   = v_q[Iw-1:0];
    dist_we    = 1'b0;
    dist_waddr = u_q[Iw-1:0];
    dist_wdata = '0;
    dist_raddr = node_q;
    q_we       = 1'b0;
    q_waddr    = tail_q[Iw-1:0];
    q_wdata    = u_q[Iw-1:0];
    q_raddr    = head_q[Iw-1:0];
    st_we      = 1'b0;
    st_waddr   = sp_q[Iw-1:0];
    st_wdata   = {node_q, v_q};
    st_raddr   = k_q[Iw-1:0];

    case (state_q)
      S_LOAD: begin
        if (in_valid_i) begin
          if (cnt_q < CntMax) begin
            rec_we = 1'b1;
            cnt_d  = cnt_q + One;
          end else begin
            ovf_d = 1'b1;
          end
          if (last_user_i) begin
            u_d     = '0;
            state_d = S_INIT;
          end
        end
      end
      // partner and layer rams back to none
      S_INIT: begin
        lp_we   = 1'b1;
        rp_we   = 1'b1;
        dist_we = 1'b1;
        match_d = '0;
        if (u_q == CntMax - One) begin
          u_d     = '0;
          state_d = S_BU;
        end else begin
          u_d = u_q + One;
        end
      end
      S_BU: begin
        rec_raddr = u_q[Iw-1:0];
        state_d   = S_BUW;
      end
      S_BUW: begin
        mask_d  = rec_rdata[MaskW-1:0];
        v_d     = '0;
        row_d   = '0;
        state_d = S_BV;
      end
      S_BV: begin
        rec_raddr = v_q[Iw-1:0];
        state_d   = S_BVW;
      end
      S_BVW: begin
        row_d = row_q | (MaxUsers'(bv_bit) << v_q[Iw-1:0]);
        v_d   = v_q + One;
        if (v_q + One == cnt_q) begin
          adj_we    = 1'b1;
          adj_wdata = row_d;
          u_d       = u_q + One;
          if (u_q + One == cnt_q) begin
            u_d     = '0;
            tail_d  = '0;
            found_d = 1'b0;
            state_d = S_LI;
          end else begin
            state_d = S_BU;
          end
        end else begin
          state_d = S_BV;
        end
      end
      // layering: seed queue with free users
      S_LI: begin
        if (u_q == cnt_q) begin
          head_d  = '0;
          state_d = S_LQ;
        end else begin
          lp_raddr = u_q[Iw-1:0];
          state_d  = S_LIW;
        end
      end
      S_LIW: begin
        dist_we    = 1'b1;
        dist_waddr = u_q[Iw-1:0];
        if (!lp_rdata[Pw-1]) begin
          dist_wdata = {1'b1, Cw'(0)};
          q_we       = 1'b1;
          tail_d     = tail_q + One;
        end else begin
          dist_wdata = '0;
        end
        u_d     = u_q + One;
        state_d = S_LI;
      end
      S_LQ: begin
        if (head_q == tail_q) begin
          u_d     = '0;
          state_d = found_q ? S_AU : S_OR;
        end else begin
          q_raddr = head_q[Iw-1:0];
          state_d = S_LQW;
        end
      end
      S_LQW: begin
        node_d     = q_rdata;
        adj_raddr  = q_rdata;
        dist_raddr = q_rdata;
        head_d     = head_q + One;
        state_d    = S_LQA;
      end
      S_LQA: begin
        row_d   = adj_rdata;
        du_d    = dist_rdata[Cw-1:0];
        v_d     = '0;
        state_d = S_LV;
      end
      S_LV: begin
        if (v_q == cnt_q) begin
          state_d = S_LQ;
        end else if (!row_q[v_q[Iw-1:0]]) begin
          v_d = v_q + One;
        end else begin
          rp_raddr = v_q[Iw-1:0];
          state_d  = S_LVW;
        end
      end
      S_LVW: begin
        if (!rp_rdata[Pw-1]) begin
          found_d = 1'b1;
          v_d     = v_q + One;
          state_d = S_LV;
        end else begin
          w_d        = rp_rdata[Iw-1:0];
          dist_raddr = rp_rdata[Iw-1:0];
          state_d    = S_LVD;
        end
      end
      S_LVD: begin
        if (!dist_rdata[Dw-1] && tail_q < CntMax) begin
          dist_we    = 1'b1;
          dist_waddr = w_q;
          dist_wdata = {1'b1, du_q + One};
          q_we       = 1'b1;
          q_wdata    = w_q;
          tail_d     = tail_q + One;
        end
        v_d     = v_q + One;
        state_d = S_LV;
      end
      // augmenting searches from each free root
      S_AU: begin
        if (u_q == cnt_q) begin
          u_d     = '0;
          tail_d  = '0;
          found_d = 1'b0;
          state_d = S_LI;
        end else begin
          lp_raddr = u_q[Iw-1:0];
          state_d  = S_AUW;
        end
      end
      S_AUW: begin
        if (lp_rdata[Pw-1]) begin
          u_d     = u_q + One;
          state_d = S_AU;
        end else begin
          sp_d    = '0;
          node_d  = u_q[Iw-1:0];
          v_d     = '0;
          state_d = S_AF;
        end
      end
      S_AF: begin
        adj_raddr  = node_q;
        dist_raddr = node_q;
        state_d    = S_AFW;
      end
      S_AFW: begin
        row_d   = adj_rdata;
        du_d    = dist_rdata[Cw-1:0];
        state_d = S_AN;
      end
      S_AN: begin
        if (v_q == cnt_q) begin
          // dead end: drop the node from the layering, pop a frame or move to the next root
          dist_we    = 1'b1;
          dist_waddr = node_q;
          dist_wdata = '0;
          if (sp_q == '0) begin
            u_d     = u_q + One;
            state_d = S_AU;
          end else begin
            st_raddr = sp_q[Iw-1:0] - Iw'(1);
            sp_d     = sp_q - One;
            state_d  = S_APW;
          end
        end else if (!row_q[v_q[Iw-1:0]]) begin
          v_d = v_q + One;
        end else begin
          rp_raddr = v_q[Iw-1:0];
          state_d  = S_ANW;
        end
      end
      S_ANW: begin
        if (!rp_rdata[Pw-1]) begin
          // free partner found: flip the top frame, then the stacked ones
          lp_we    = 1'b1;
          lp_waddr = node_q;
          lp_wdata = {1'b1, v_q[Iw-1:0]};
          rp_we    = 1'b1;
          rp_waddr = v_q[Iw-1:0];
          rp_wdata = {1'b1, node_q};
          if (sp_q == '0) begin
            match_d = match_q + One;
            u_d     = u_q + One;
            state_d = S_AU;
          end else begin
            k_d     = sp_q - One;
            state_d = S_AC;
          end
        end else begin
          w_d        = rp_rdata[Iw-1:0];
          dist_raddr = rp_rdata[Iw-1:0];
          state_d    = S_AND;
        end
      end
      S_AND: begin
        if (dist_rdata[Dw-1] && dist_rdata[Cw-1:0] == du_q + One &&
            sp_q + One < CntMax) begin
          st_we   = 1'b1;
          sp_d    = sp_q + One;
          node_d  = w_q;
          v_d     = '0;
          state_d = S_AF;
        end else begin
          v_d     = v_q + One;
          state_d = S_AN;
        end
      end
      S_APW: begin
        node_d  = st_rdata[Sw-1 -: Iw];
        v_d     = st_rdata[Cw-1:0] + One;
        state_d = S_AF;
      end
      S_AC: begin
        st_raddr = k_q[Iw-1:0];
        state_d  = S_ACW;
      end
      S_ACW: begin
        lp_we    = 1'b1;
        lp_waddr = st_rdata[Sw-1 -: Iw];
        lp_wdata = {1'b1, st_rdata[Iw-1:0]};
        rp_we    = 1'b1;
        rp_waddr = st_rdata[Iw-1:0];
        rp_wdata = {1'b1, st_rdata[Sw-1 -: Iw]};
        if (k_q == '0) begin
          match_d = match_q + One;
          u_d     = u_q + One;
          state_d = S_AU;
        end else begin
          k_d     = k_q - One;
          state_d = S_AC;
        end
      end
      // one result beat per stored user
      S_OR: begin
        lp_raddr = u_q[Iw-1:0];
        rp_raddr = u_q[Iw-1:0];
        if (!out_valid_q) begin
          state_d = S_OW;
        end
      end
      S_OW: begin
        out_load = 1'b1;
        u_d      = u_q + One;
        if (u_q + One == cnt_q) begin
          cnt_d   = '0;
          ovf_d   = 1'b0;
          state_d = S_LOAD;
        end else begin
          state_d = S_OR;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      u_q         <= '0;
      v_q         <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      found_q     <= 1'b0;
      sp_q        <= '0;
      k_q         <= '0;
      match_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      u_q         <= u_d;
      v_q         <= v_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      found_q     <= found_d;
      sp_q        <= sp_d;
      k_q         <= k_d;
      match_q     <= match_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    row_q  <= row_d;
    mask_q <= mask_d;
    du_q   <= du_d;
    node_q <= node_d;
    w_q    <= w_d;
    if (out_load) begin
      res_user_q <= u_q[Iw-1:0];
      res_lp_q   <= lp_rdata;
      res_rp_q   <= rp_rdata;
      res_tot_q  <= match_q;
      res_ovf_q  <= ovf_q;
      res_last_q <= (u_q + One == cnt_q);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign user_index_o    = IdxW'(res_user_q);
  assign is_matched_o    = res_lp_q[Pw-1];
  assign partner_index_o = res_lp_q[Pw-1] ? IdxW'(res_lp_q[Iw-1:0]) : '0;
  assign has_guest_o     = res_rp_q[Pw-1];
  assign guest_index_o   = res_rp_q[Pw-1] ? IdxW'(res_rp_q[Iw-1:0]) : '0;
  assign matched_total_o = TotW'(res_tot_q);
  assign overflow_o      = res_ovf_q;
  assign last_result_o   = res_last_q;

  bmm_ram #(.Width(Rw), .Depth(MaxUsers)) u_rec_ram (
    .clk_i, .we_i(rec_we), .waddr_i(rec_waddr), .wdata_i(rec_wdata),
    .raddr_i(rec_raddr), .rdata_o(rec_rdata)
  );

  bmm_ram #(.Width(MaxUsers), .Depth(MaxUsers)) u_adj_ram (
    .clk_i, .we_i(adj_we), .waddr_i(adj_waddr), .wdata_i(adj_wdata),
    .raddr_i(adj_raddr), .rdata_o(adj_rdata)
  );

  bmm_ram #(.Width(Pw), .Depth(MaxUsers)) u_lp_ram (
    .clk_i, .we_i(lp_we), .waddr_i(lp_waddr), .wdata_i(lp_wdata),
    .raddr_i(lp_raddr), .rdata_o(lp_rdata)
  );

  bmm_ram #(.Width(Pw), .Depth(MaxUsers)) u_rp_ram (
    .clk_i, .we_i(rp_we), .waddr_i(rp_waddr), .wdata_i(rp_wdata),
    .raddr_i(rp_raddr), .rdata_o(rp_rdata)
  );

  bmm_ram #(.Width(Dw), .Depth(MaxUsers)) u_dist_ram (
    .clk_i, .we_i(dist_we), .waddr_i(dist_waddr), .wdata_i(dist_wdata),
    .raddr_i(dist_raddr), .rdata_o(dist_rdata)
  );

  bmm_ram #(.Width(Iw), .Depth(MaxUsers)) u_queue_ram (
    .clk_i, .we_i(q_we), .waddr_i(q_waddr), .wdata_i(q_wdata),
    .raddr_i(q_raddr), .rdata_o(q_rdata)
  );

  bmm_ram #(.Width(Sw), .Depth(MaxUsers)) u_stack_ram (
    .clk_i, .we_i(st_we), .waddr_i(st_waddr), .wdata_i(st_wdata),
    .raddr_i(st_raddr), .rdata_o(st_rdata)
  );

endmodule
